// ----- sv/ffl_pkg.sv -----
// Shared types, constants and helper functions for the forest-fire lattice core.
// Depends on nothing; ffl_engine, the top level and the testbench import it.
package ffl_pkg;

    localparam int SIDE    = 128;
    localparam int CELLS   = SIDE * SIDE;
    localparam int ADDR_W  = $clog2(CELLS);
    localparam int CRD_W   = (($clog2(SIDE) > 7) ? $clog2(SIDE) : 7) + 1;
    localparam int CNT_W   = $clog2(CELLS + 1);
    localparam int PROD_W  = ADDR_W + CRD_W;

    localparam int ROW_W   = 7;
    localparam int DRAW_W  = 16;
    localparam int THR_W   = 16;
    localparam int STATE_W = 2;
    localparam int COUNT_W = 15;
    localparam int TOTAL_W = 32;
    localparam int CFG_IDX_W = 1;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 15'h7FFF;

    localparam logic [STATE_W-1:0] CELL_EMPTY   = 2'd0;
    localparam logic [STATE_W-1:0] CELL_TREE    = 2'd1;
    localparam logic [STATE_W-1:0] CELL_BURNING = 2'd2;

    localparam logic KIND_UPDATE = 1'b0;
    localparam logic KIND_COMMIT = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_GROW = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FIRE = 1'b1;

    localparam logic [THR_W-1:0] GROW_RESET = 16'd13107;
    localparam logic [THR_W-1:0] FIRE_RESET = 16'd66;

    // Neighbor offsets: up, down, left, right.
    localparam logic signed [1:0] STEP_ROW [4] = '{-2'sd1, 2'sd1, 2'sd0, 2'sd0};
    localparam logic signed [1:0] STEP_COL [4] = '{2'sd0, 2'sd0, -2'sd1, 2'sd1};

    typedef logic [ADDR_W-1:0] t_addr;

    typedef struct packed {
        logic              kind;
        logic [ROW_W-1:0]  row;
        logic [ROW_W-1:0]  col;
        logic [DRAW_W-1:0] draw;
    } t_item;

    typedef struct packed {
        logic               we;
        t_addr              waddr;
        logic [STATE_W-1:0] wdata;
        t_addr              raddr;
    } t_mem_req;

    typedef struct packed {
        logic [TOTAL_W-1:0] burned;
        logic [TOTAL_W-1:0] ign;
        logic [COUNT_W-1:0] burning;
        logic [COUNT_W-1:0] tree;
        logic [COUNT_W-1:0] empty;
        logic [STATE_W-1:0] state;
    } t_result;

    function automatic t_addr cell_addr(input logic [CRD_W-1:0] r, input logic [CRD_W-1:0] c);
        logic [PROD_W-1:0] p;
        p = PROD_W'(r) * PROD_W'(SIDE) + PROD_W'(c);
        return p[ADDR_W-1:0];
    endfunction

    function automatic logic [COUNT_W-1:0] sat_count(input logic [CNT_W-1:0] v);
        logic [COUNT_W-1:0] res;
        if (32'(v) > 32'(COUNT_MAX)) begin
            res = COUNT_MAX;
        end else begin
            res = COUNT_W'(v);
        end
        return res;
    endfunction

    function automatic logic [TOTAL_W-1:0] sat_inc(input logic [TOTAL_W-1:0] v);
        logic [TOTAL_W-1:0] res;
        if (v == {TOTAL_W{1'b1}}) begin
            res = v;
        end else begin
            res = v + TOTAL_W'(1);
        end
        return res;
    endfunction

endpackage

// ----- sv/ffl_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
// Depends on nothing.
module ffl_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/ffl_engine.sv -----
// Sequencer of the forest-fire core: clearing pass, cell update and commit sweep.
// Depends on ffl_pkg; drives the request ports of the two grid memories.
module ffl_engine
    import ffl_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  t_item              i_item,
    output logic               o_ready,
    input  logic [THR_W-1:0]   i_grow,
    input  logic [THR_W-1:0]   i_fire,
    output t_mem_req           o_pres_req,
    input  logic [STATE_W-1:0] i_pres_rdata,
    output t_mem_req           o_pend_req,
    input  logic [STATE_W-1:0] i_pend_rdata,
    output logic               o_res_valid,
    output t_result            o_res,
    input  logic               i_res_ready
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_UPD,
        S_SWEEP,
        S_RESULT
    } t_state;

    t_state             r_state;
    logic [2:0]         r_step;
    logic [CRD_W-1:0]   r_row;
    logic [CRD_W-1:0]   r_col;
    logic [DRAW_W-1:0]  r_draw;
    logic [ADDR_W:0]    r_addr;
    logic               r_sv;
    t_addr              r_saddr;
    t_addr              r_raddr_d;
    logic               r_rvalid_d;
    logic [STATE_W-1:0] r_cur;
    logic [TOTAL_W-1:0] r_ign;
    logic [TOTAL_W-1:0] r_burn;
    logic [CNT_W-1:0]   r_cnt_e;
    logic [CNT_W-1:0]   r_cnt_t;
    logic [CNT_W-1:0]   r_cnt_b;
    t_result            r_res;

    logic [1:0]         pos_k;
    logic [CRD_W-1:0]   pos_r;
    logic [CRD_W-1:0]   pos_c;
    logic               pos_valid;
    t_addr              pos_addr;
    logic [STATE_W-1:0] upd_state;
    logic               in_bounds;

    // Position 0 is the cell itself, positions 1 to 4 its neighbors.
    always_comb begin
        pos_k = 2'(r_step - 3'd1);
        pos_r = r_row;
        pos_c = r_col;
        if (r_step != 3'd0 && r_step <= 3'd4) begin
            pos_r = r_row + {{(CRD_W-2){STEP_ROW[pos_k][1]}}, STEP_ROW[pos_k]};
            pos_c = r_col + {{(CRD_W-2){STEP_COL[pos_k][1]}}, STEP_COL[pos_k]};
        end
        pos_valid = (pos_r < CRD_W'(SIDE)) && (pos_c < CRD_W'(SIDE)) && (r_step <= 3'd4);
        pos_addr  = cell_addr(pos_r, pos_c);
    end

    always_comb begin
        case (i_pres_rdata)
            CELL_EMPTY:   upd_state = (r_draw < i_grow) ? CELL_TREE : i_pend_rdata;
            CELL_TREE:    upd_state = (r_draw < i_fire) ? CELL_BURNING : i_pend_rdata;
            CELL_BURNING: upd_state = CELL_EMPTY;
            default:      upd_state = i_pend_rdata;
        endcase
    end

    assign in_bounds = (CRD_W'(i_item.row) < CRD_W'(SIDE)) &&
                       (CRD_W'(i_item.col) < CRD_W'(SIDE));

    always_comb begin
        o_pres_req = '0;
        o_pend_req = '0;
        case (r_state)
            S_CLEAR: begin
                o_pres_req.we    = 1'b1;
                o_pres_req.waddr = r_addr[ADDR_W-1:0];
                o_pres_req.wdata = CELL_EMPTY;
                o_pend_req.we    = 1'b1;
                o_pend_req.waddr = r_addr[ADDR_W-1:0];
                o_pend_req.wdata = CELL_EMPTY;
            end
            S_UPD: begin
                o_pres_req.raddr = pos_addr;
                o_pend_req.raddr = pos_addr;
                o_pend_req.waddr = r_raddr_d;
                if (r_step == 3'd1) begin
                    o_pend_req.we    = 1'b1;
                    o_pend_req.wdata = upd_state;
                end else if (r_step >= 3'd2) begin
                    o_pend_req.we    = r_rvalid_d && (r_cur == CELL_BURNING) &&
                                       (i_pres_rdata == CELL_TREE);
                    o_pend_req.wdata = CELL_BURNING;
                end
            end
            S_SWEEP: begin
                o_pend_req.raddr = r_addr[ADDR_W-1:0];
                o_pres_req.we    = r_sv;
                o_pres_req.waddr = r_saddr;
                o_pres_req.wdata = i_pend_rdata;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_step  <= 3'd0;
            r_addr  <= '0;
            r_sv    <= 1'b0;
            r_ign   <= '0;
            r_burn  <= '0;
        end else begin
            r_raddr_d  <= pos_addr;
            r_rvalid_d <= pos_valid;
            case (r_state)
                S_CLEAR: begin
                    if (r_addr[ADDR_W-1:0] == ADDR_W'(CELLS - 1)) begin
                        r_addr  <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_addr <= r_addr + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (i_start) begin
                        r_row   <= CRD_W'(i_item.row);
                        r_col   <= CRD_W'(i_item.col);
                        r_draw  <= i_item.draw;
                        r_step  <= 3'd0;
                        r_addr  <= '0;
                        r_sv    <= 1'b0;
                        r_cnt_e <= '0;
                        r_cnt_t <= '0;
                        r_cnt_b <= '0;
                        if (i_item.kind == KIND_COMMIT) begin
                            r_state <= S_SWEEP;
                        end else if (in_bounds) begin
                            r_state <= S_UPD;
                        end else begin
                            r_res.state   <= CELL_EMPTY;
                            r_res.empty   <= '0;
                            r_res.tree    <= '0;
                            r_res.burning <= '0;
                            r_res.ign     <= r_ign;
                            r_res.burned  <= r_burn;
                            r_state       <= S_RESULT;
                        end
                    end
                end
                S_UPD: begin
                    r_step <= r_step + 3'd1;
                    if (r_step == 3'd1) begin
                        r_cur <= i_pres_rdata;
                        if (i_pres_rdata == CELL_TREE && r_draw < i_fire) begin
                            r_ign <= sat_inc(r_ign);
                        end
                        if (i_pres_rdata == CELL_BURNING) begin
                            r_burn <= sat_inc(r_burn);
                        end
                        r_res.state <= upd_state;
                    end
                    if (r_step == 3'd5) begin
                        r_res.empty   <= '0;
                        r_res.tree    <= '0;
                        r_res.burning <= '0;
                        r_res.ign     <= r_ign;
                        r_res.burned  <= r_burn;
                        r_state       <= S_RESULT;
                    end
                end
                S_SWEEP: begin
                    if (r_addr != (ADDR_W + 1)'(CELLS)) begin
                        r_addr  <= r_addr + 1'b1;
                        r_saddr <= r_addr[ADDR_W-1:0];
                        r_sv    <= 1'b1;
                    end else begin
                        r_sv <= 1'b0;
                    end
                    if (r_sv) begin
                        case (i_pend_rdata)
                            CELL_EMPTY:   r_cnt_e <= r_cnt_e + 1'b1;
                            CELL_TREE:    r_cnt_t <= r_cnt_t + 1'b1;
                            CELL_BURNING: r_cnt_b <= r_cnt_b + 1'b1;
                            default: begin
                            end
                        endcase
                    end
                    if (r_addr == (ADDR_W + 1)'(CELLS) && !r_sv) begin
                        r_res.state   <= CELL_EMPTY;
                        r_res.empty   <= sat_count(r_cnt_e);
                        r_res.tree    <= sat_count(r_cnt_t);
                        r_res.burning <= sat_count(r_cnt_b);
                        r_res.ign     <= r_ign;
                        r_res.burned  <= r_burn;
                        r_state       <= S_RESULT;
                    end
                end
                S_RESULT: begin
                    if (i_res_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_RESULT);
    assign o_res       = r_res;

    // The present grid is only written by the clearing pass and the commit sweep.
    a_pres_write_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pres_req.we |-> (r_state == S_CLEAR || r_state == S_SWEEP))
        else $error("present grid written outside clear or sweep");

    // Neighbor writes during an update only ever set a cell to burning.
    a_nbr_write_burning: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD && r_step >= 3'd2 && o_pend_req.we) |->
        (o_pend_req.wdata == CELL_BURNING && r_cur == CELL_BURNING))
        else $error("bad neighbor write");

    // An item is only taken while the sequencer is idle.
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> r_state == S_IDLE)
        else $error("item started while busy");

    // The running totals never decrease.
    a_totals_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_ign >= $past(r_ign) && r_burn >= $past(r_burn)))
        else $error("running total went down");

endmodule

// ----- sv/forest_fire_lattice_step_core.sv -----
// Top level of the forest-fire lattice core: stream ports, configuration
// registers, the two grid memories and the result register. Uses ffl_pkg,
// ffl_ram and ffl_engine.
//
// The block keeps a SIDE x SIDE forest-fire lattice in two on-chip memories, a
// present grid that updates read and a pending grid that they build. After
// reset a clearing pass writes every cell empty, one cell a cycle, so no beat
// is taken until it is done; configuration writes are taken at any time. Each
// input beat is handled to completion before the next is taken. An in-bounds
// update beat runs six sequencer steps, in which the read ports of both grids
// visit the cell and then each of its four neighbors, one a cycle, and the
// write for the last neighbor lands in the sixth step; then a result state
// hands the result to the output register, and the idle state takes the next
// beat. An update outside the lattice goes from idle straight to the result
// state. A commit beat sweeps the whole lattice through the pending grid's
// read port once, copying into the present grid and counting.
// Results wait in an output register, so a stalled master side only holds
// up the block once that register and the sequencer's result are full.
module forest_fire_lattice_step_core
    import ffl_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Slave side: one beat per update or commit item.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [31:0]          s_tdata,   // cell_row[6:0], cell_col[13:7], random_draw[29:14]
    input  logic                 s_tuser,   // kind[0]: 0 update, 1 commit
    // Master side: one result beat per input beat.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [111:0]         m_tdata,   // new_cell_state[1:0], empty_count[16:2],
                                            // tree_count[31:17], burning_count[46:32],
                                            // ignition_total[78:47], burned_total[110:79]
    // Configuration write channel.
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [THR_W-1:0]     i_cfg_data
);

    logic [THR_W-1:0]   r_grow;
    logic [THR_W-1:0]   r_fire;
    logic               r_out_valid;
    t_result            r_out;

    t_item              item;
    logic               eng_ready;
    logic               eng_start;
    t_mem_req           pres_req;
    t_mem_req           pend_req;
    logic [STATE_W-1:0] pres_rdata;
    logic [STATE_W-1:0] pend_rdata;
    logic               res_valid;
    t_result            res;
    logic               res_ready;

    // Unpack the slave beat into the item fields.
    assign item.kind = s_tuser;
    assign item.row  = s_tdata[6:0];
    assign item.col  = s_tdata[13:7];
    assign item.draw = s_tdata[29:14];

    assign s_tready  = eng_ready;
    assign eng_start = s_tvalid && eng_ready;

    // Thresholds are plain registers; writes are always accepted.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grow <= GROW_RESET;
            r_fire <= FIRE_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_GROW: r_grow <= i_cfg_data;
                REG_FIRE: r_fire <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    ffl_ram #(
        .WIDTH(STATE_W),
        .DEPTH(CELLS)
    ) u_present (
        .i_clk   (i_clk),
        .i_we    (pres_req.we),
        .i_waddr (pres_req.waddr),
        .i_wdata (pres_req.wdata),
        .i_raddr (pres_req.raddr),
        .o_rdata (pres_rdata)
    );

    ffl_ram #(
        .WIDTH(STATE_W),
        .DEPTH(CELLS)
    ) u_pending (
        .i_clk   (i_clk),
        .i_we    (pend_req.we),
        .i_waddr (pend_req.waddr),
        .i_wdata (pend_req.wdata),
        .i_raddr (pend_req.raddr),
        .o_rdata (pend_rdata)
    );

    ffl_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (eng_start),
        .i_item       (item),
        .o_ready      (eng_ready),
        .i_grow       (r_grow),
        .i_fire       (r_fire),
        .o_pres_req   (pres_req),
        .i_pres_rdata (pres_rdata),
        .o_pend_req   (pend_req),
        .i_pend_rdata (pend_rdata),
        .o_res_valid  (res_valid),
        .o_res        (res),
        .i_res_ready  (res_ready)
    );

    // The output register takes a result whenever it is empty or being drained.
    assign res_ready = !r_out_valid || m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (res_valid && res_ready) begin
                r_out_valid <= 1'b1;
                r_out       <= res;
            end else if (m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {1'b0, r_out};

endmodule

// ----- sim/forest_fire_lattice_step_core_tb.sv -----
// Self-checking testbench for forest_fire_lattice_step_core: directed table, then random
// generations on small windows of the lattice, checked against a predictor of the lattice.
// Depends on ffl_pkg and the core's RTL only.
module forest_fire_lattice_step_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ffl_pkg::*;

    // A commit sweeps the whole lattice, and so does the clearing pass after reset.
    // No accepted beat for several times as long as a sweep means a hang.
    localparam int IDLE_LIMIT    = 80000;
    localparam int SETTLE_CYCLES = 16;
    localparam int PHASES        = 5;
    localparam int PHASE_ITEMS   = 300;
    localparam int COMMIT_ODDS   = 60;   // one commit in this many random items
    localparam int WIN           = 6;    // side of the window where updates pile up
    localparam int MAX_PRINTS    = 40;

    localparam int ROW_STEP [4] = '{-1, 1, 0, 0};
    localparam int COL_STEP [4] = '{0, 0, -1, 1};

    typedef struct packed {
        logic               typed;      // expected result given below, not predicted
        logic               kind;
        logic [ROW_W-1:0]   row;
        logic [ROW_W-1:0]   col;
        logic [DRAW_W-1:0]  draw;
        logic [STATE_W-1:0] want_state;
        logic [COUNT_W-1:0] want_empty;
    } t_dir_row;

    // Directed part, run with the thresholds at their reset values (grow 13107, fire 66).
    // Trees are planted at the corners, lit, and left to spread along the lattice edges.
    localparam t_dir_row DIRECTED [25] = '{
        // Commit straight after reset: the whole lattice is empty.
        '{1'b1, KIND_COMMIT, 7'd0,   7'd0,   16'd0,     CELL_EMPTY, 15'd16384},
        '{1'b1, KIND_UPDATE, 7'd0,   7'd0,   16'd0,     CELL_TREE,  15'd0},
        '{1'b1, KIND_UPDATE, 7'd127, 7'd127, 16'hFFFF,  CELL_EMPTY, 15'd0},
        '{1'b0, KIND_UPDATE, 7'd0,   7'd1,   16'd13106, CELL_EMPTY, 15'd0},
        '{1'b0, KIND_UPDATE, 7'd1,   7'd0,   16'd13107, CELL_EMPTY, 15'd0},
        '{1'b0, KIND_UPDATE, 7'd1,   7'd0,   16'd1,     CELL_EMPTY, 15'd0},
        '{1'b0, KIND_UPDATE, 7'd0,   7'd127, 16'd2,     CELL_EMPTY, 15'd0},
        '{1'b0, KIND_UPDATE, 7'd127, 7'd0,   16'd3,     CELL_EMPTY, 15'd0},
        '{1'b0, KIND_UPDATE, 7'd126, 7'd0,   16'd4,     CELL_EMPTY, 15'd0},
        '{1'b0, KIND_UPDATE, 7'd127, 7'd1,   16'd5,     CELL_EMPTY, 15'd0},
        '{1'b0, KIND_UPDATE, 7'd85,  7'd42,  16'h5555,  CELL_EMPTY, 15'd0},
        '{1'b0, KIND_UPDATE, 7'd42,  7'd85,  16'h2AAA,  CELL_EMPTY, 15'd0},
        '{1'b0, KIND_COMMIT, 7'd0,   7'd0,   16'd0,     CELL_EMPTY, 15'd0},
        '{1'b0, KIND_UPDATE, 7'd0,   7'd0,   16'd65,    CELL_EMPTY, 15'd0},
        '{1'b0, KIND_UPDATE, 7'd127, 7'd0,   16'd0,     CELL_EMPTY, 15'd0},
        '{1'b0, KIND_UPDATE, 7'd0,   7'd127, 16'd66,    CELL_EMPTY, 15'd0},
        '{1'b0, KIND_UPDATE, 7'd42,  7'd85,  16'hFFFF,  CELL_EMPTY, 15'd0},
        '{1'b0, KIND_COMMIT, 7'd127, 7'd127, 16'hFFFF,  CELL_EMPTY, 15'd0},
        '{1'b0, KIND_UPDATE, 7'd0,   7'd0,   16'hFFFF,  CELL_EMPTY, 15'd0},
        '{1'b0, KIND_UPDATE, 7'd127, 7'd0,   16'hFFFF,  CELL_EMPTY, 15'd0},
        '{1'b0, KIND_UPDATE, 7'd0,   7'd1,   16'd0,     CELL_EMPTY, 15'd0},
        '{1'b0, KIND_UPDATE, 7'd1,   7'd0,   16'hFFFF,  CELL_EMPTY, 15'd0},
        '{1'b0, KIND_COMMIT, 7'd0,   7'd0,   16'd0,     CELL_EMPTY, 15'd0},
        '{1'b0, KIND_UPDATE, 7'd0,   7'd1,   16'hFFFF,  CELL_EMPTY, 15'd0},
        '{1'b0, KIND_COMMIT, 7'd0,   7'd0,   16'd0,     CELL_EMPTY, 15'd0}
    };

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [31:0]          s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [111:0]         m_tdata;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [THR_W-1:0]     i_cfg_data;

    // Predictor state: both generations of the lattice, the totals and the thresholds.
    logic [STATE_W-1:0] lattice_now  [CELLS];
    logic [STATE_W-1:0] lattice_next [CELLS];
    logic [TOTAL_W-1:0] ignitions;
    logic [TOTAL_W-1:0] burnouts;
    logic [THR_W-1:0]   grow_thr;
    logic [THR_W-1:0]   fire_thr;

    t_result awaited_results [$];
    int      mismatches   = 0;
    int      results_seen = 0;
    int      updates_sent;
    int      commits_sent;
    int      idle_cycles  = 0;
    bit      calm;   // when set, neither side idles

    forest_fire_lattice_step_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Work out the result of one accepted item and move the lattice on.
    task automatic advance_lattice(input logic kind, input logic [ROW_W-1:0] row,
                                   input logic [ROW_W-1:0] col, input logic [DRAW_W-1:0] draw,
                                   output t_result res);
        int at;
        int nr;
        int nc;
        int k;
        int i;
        int tally [3];
        logic [STATE_W-1:0] cur;
        res = '0;
        if (kind == KIND_COMMIT) begin
            tally = '{0, 0, 0};
            for (i = 0; i < CELLS; i++) begin
                lattice_now[i] = lattice_next[i];
                if (lattice_now[i] < 2'd3) begin
                    tally[lattice_now[i]]++;
                end
            end
            res.empty   = (tally[0] > int'(COUNT_MAX)) ? COUNT_MAX : COUNT_W'(tally[0]);
            res.tree    = (tally[1] > int'(COUNT_MAX)) ? COUNT_MAX : COUNT_W'(tally[1]);
            res.burning = (tally[2] > int'(COUNT_MAX)) ? COUNT_MAX : COUNT_W'(tally[2]);
        end else if (int'(row) < SIDE && int'(col) < SIDE) begin
            at  = int'(row) * SIDE + int'(col);
            cur = lattice_now[at];
            case (cur)
                CELL_EMPTY: begin
                    if (draw < grow_thr) begin
                        lattice_next[at] = CELL_TREE;
                    end
                end
                CELL_TREE: begin
                    if (draw < fire_thr) begin
                        if (ignitions != '1) begin
                            ignitions = ignitions + 1'b1;
                        end
                        lattice_next[at] = CELL_BURNING;
                    end
                end
                CELL_BURNING: begin
                    // Only trees of the present generation catch fire; off-lattice
                    // neighbors at the edges are skipped.
                    for (k = 0; k < 4; k++) begin
                        nr = int'(row) + ROW_STEP[k];
                        nc = int'(col) + COL_STEP[k];
                        if (nr >= 0 && nr < SIDE && nc >= 0 && nc < SIDE) begin
                            if (lattice_now[nr * SIDE + nc] == CELL_TREE) begin
                                lattice_next[nr * SIDE + nc] = CELL_BURNING;
                            end
                        end
                    end
                    if (burnouts != '1) begin
                        burnouts = burnouts + 1'b1;
                    end
                    lattice_next[at] = CELL_EMPTY;
                end
                default: begin
                end
            endcase
            res.state = lattice_next[at];
        end
        res.ign    = ignitions;
        res.burned = burnouts;
    endtask

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        if (mismatches < MAX_PRINTS) begin
            $display("%0t: result %0d %s: got %0d, expected %0d",
                     $realtime, results_seen, what, got, want);
        end
        mismatches++;
    endtask

    // Offer one item on the slave side, after a random gap, and record what it should give.
    // The valid is only lowered inside a gap, so back-to-back beats keep it high.
    task automatic push_item(input logic kind, input logic [ROW_W-1:0] row,
                             input logic [ROW_W-1:0] col, input logic [DRAW_W-1:0] draw,
                             input bit typed, input t_result typed_want);
        t_result want;
        while (!calm && $urandom_range(0, 99) < 35) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {2'b00, draw, col, row};
        do @(posedge i_clk); while (!s_tready);
        advance_lattice(kind, row, col, draw, want);
        if (typed) begin
            want = typed_want;
        end
        awaited_results.push_back(want);
        if (kind == KIND_COMMIT) begin
            commits_sent++;
        end else begin
            updates_sent++;
        end
    endtask

    // Stop offering beats, wait until every result has come back, then let the core settle.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (awaited_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Both thresholds in two back-to-back beats on the configuration channel.
    task automatic set_thresholds(input logic [THR_W-1:0] grow, input logic [THR_W-1:0] fire);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= REG_GROW;
        i_cfg_data  <= grow;
        do @(posedge i_clk); while (!o_cfg_ready);
        grow_thr = grow;
        i_cfg_index <= REG_FIRE;
        i_cfg_data  <= fire;
        do @(posedge i_clk); while (!o_cfg_ready);
        fire_thr = fire;
        i_cfg_valid <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        m_tready <= calm || ($urandom_range(0, 99) >= 35);
    end

    // Result checker: every master beat is compared with the oldest expectation.
    always @(posedge i_clk) begin : result_check
        t_result got;
        t_result want;
        if (i_rst_n && m_tvalid && m_tready) begin
            got = m_tdata[110:0];
            if (awaited_results.size() == 0) begin
                flag_mismatch("arrived with nothing expected, state", 32'(got.state), 32'd0);
            end else begin
                want = awaited_results.pop_front();
                if (got.state != want.state)
                    flag_mismatch("new_cell_state", 32'(got.state), 32'(want.state));
                if (got.empty != want.empty)
                    flag_mismatch("empty_count", 32'(got.empty), 32'(want.empty));
                if (got.tree != want.tree)
                    flag_mismatch("tree_count", 32'(got.tree), 32'(want.tree));
                if (got.burning != want.burning)
                    flag_mismatch("burning_count", 32'(got.burning), 32'(want.burning));
                if (got.ign != want.ign)
                    flag_mismatch("ignition_total", got.ign, want.ign);
                if (got.burned != want.burned)
                    flag_mismatch("burned_total", got.burned, want.burned);
            end
            results_seen++;
        end
    end

    // Watchdog: counts cycles in which no beat moves on any channel.
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $realtime, IDLE_LIMIT);
            $display("[forest_fire_lattice_step_core] ERROR");
            $finish;
        end
    end

    initial begin : stimulus
        t_dir_row          entry;
        t_result           typed_want;
        logic              kind;
        logic [ROW_W-1:0]  r;
        logic [ROW_W-1:0]  c;
        logic [DRAW_W-1:0] d;
        int                phase;
        int                n;
        int                i;
        int                win;
        int                r0;
        int                c0;
        int                off;
        int                pick;

        for (i = 0; i < CELLS; i++) begin
            lattice_now[i]  = CELL_EMPTY;
            lattice_next[i] = CELL_EMPTY;
        end
        ignitions    = '0;
        burnouts     = '0;
        grow_thr     = GROW_RESET;
        fire_thr     = FIRE_RESET;
        updates_sent = 0;
        commits_sent = 0;
        calm         = 1'b0;
        win          = 0;
        r0           = 0;
        c0           = 0;

        i_rst_n     <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tuser     <= KIND_UPDATE;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= REG_GROW;
        i_cfg_data  <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The directed rows go in right away; the core holds them off until its
        // clearing pass is done.
        for (n = 0; n < $size(DIRECTED); n++) begin
            entry            = DIRECTED[n];
            typed_want       = '0;
            typed_want.state = entry.want_state;
            typed_want.empty = entry.want_empty;
            push_item(entry.kind, entry.row, entry.col, entry.draw, entry.typed, typed_want);
        end

        // Random part: several threshold settings. Most updates land in a small window
        // (a corner or a spot inside) so that cells are revisited across generations and
        // fires can grow and spread; the rest are scattered over the whole lattice.
        for (phase = 0; phase < PHASES; phase++) begin
            settle();
            case (phase)
                0: set_thresholds(16'hFFFF, 16'hFFFF);
                1: set_thresholds(16'd0, 16'd0);
                2: set_thresholds(16'($urandom_range(8000, 40000)),
                                  16'($urandom_range(2000, 30000)));
                3: set_thresholds(16'd1, 16'd1);
                default: set_thresholds(16'($urandom), 16'($urandom));
            endcase
            // One whole phase runs without idling on either side.
            calm = (phase == 2);
            win  = $urandom_range(0, 4);
            r0   = $urandom_range(1, SIDE - WIN - 1);
            c0   = $urandom_range(1, SIDE - WIN - 1);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                r = 7'($urandom);
                c = 7'($urandom);
                if ($urandom_range(0, COMMIT_ODDS - 1) == 0) begin
                    kind = KIND_COMMIT;
                    d    = 16'($urandom);
                end else begin
                    kind = KIND_UPDATE;
                    if ($urandom_range(0, 9) < 8) begin
                        off = $urandom_range(0, WIN - 1);
                        if (win == 4)
                            r = 7'(r0 + off);
                        else if (win < 2)
                            r = 7'(off);
                        else
                            r = 7'(SIDE - 1 - off);
                        off = $urandom_range(0, WIN - 1);
                        if (win == 4)
                            c = 7'(c0 + off);
                        else if (win == 0 || win == 2)
                            c = 7'(off);
                        else
                            c = 7'(SIDE - 1 - off);
                    end
                    pick = $urandom_range(0, 19);
                    if (pick < 12)
                        d = 16'($urandom);
                    else if (pick < 14)
                        d = 16'(int'(grow_thr) + $urandom_range(0, 2) - 1);
                    else if (pick < 16)
                        d = 16'(int'(fire_thr) + $urandom_range(0, 2) - 1);
                    else if (pick < 18)
                        d = 16'd0;
                    else
                        d = 16'hFFFF;
                end
                push_item(kind, r, c, d, 1'b0, '0);
                // A new generation sometimes moves to another window.
                if (kind == KIND_COMMIT && $urandom_range(0, 2) == 0) begin
                    win = $urandom_range(0, 4);
                    r0  = $urandom_range(1, SIDE - WIN - 1);
                    c0  = $urandom_range(1, SIDE - WIN - 1);
                end
            end
        end

        calm = 1'b1;
        settle();
        $display("Covered %0d cell updates and %0d commits over %0d threshold settings,",
                 updates_sent, commits_sent, PHASES + 1);
        $display("ending with %0d ignitions and %0d burned-out cells; %0d results checked.",
                 ignitions, burnouts, results_seen);
        if (mismatches == 0) begin
            $display("[forest_fire_lattice_step_core] OK");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("[forest_fire_lattice_step_core] ERROR");
        end
        $finish;
    end

endmodule
